// ----- rtl/sh5_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh5_pkg
// Types, codes and helpers shared by the SOCKS5 handshake parser.
// ----------------------------------------------------------------------------
package sh5_pkg;

	localparam logic [7:0] PROTO_VER = 8'd5;
	localparam logic [7:0] NO_METHOD = 8'hFF;

	localparam logic [7:0] AT_CODE_V4   = 8'd1;
	localparam logic [7:0] AT_CODE_NAME = 8'd3;
	localparam logic [7:0] AT_CODE_V6   = 8'd4;

	localparam logic [7:0] REQ_CONNECT = 8'd1;

	localparam logic [7:0] LEN_IPV4 = 8'd4;
	localparam logic [7:0] LEN_IPV6 = 8'd16;

	localparam logic [7:0] REP_UNSUPPORTED = 8'd7;

	// reply burst lengths
	localparam logic [3:0] N_GREET_OK = 4'd2;
	localparam logic [3:0] N_GREET_NO = 4'd3;
	localparam logic [3:0] N_REPLY    = 4'd10;
	localparam logic [3:0] N_REPLY_CL = 4'd11;
	localparam logic [3:0] REPLY_ATYP_IDX = 4'd3;

	typedef enum logic [1:0] {
		FUNC_CLIENT  = 2'd0,
		FUNC_OUTCOME = 2'd1,
		FUNC_REMOTE  = 2'd2,
		FUNC_HANGUP  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		KIND_CLIENT  = 3'd0,
		KIND_REMOTE  = 3'd1,
		KIND_ADDR    = 3'd2,
		KIND_CONNECT = 3'd3,
		KIND_CLOSE   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		DK_IPV4   = 2'd0,
		DK_DOMAIN = 2'd1,
		DK_IPV6   = 2'd2
	} dkind_t;

	typedef enum logic [1:0] {
		CAUSE_PROTO   = 2'd0,
		CAUSE_NOAUTH  = 2'd1,
		CAUSE_CMD     = 2'd2,
		CAUSE_HANGUP  = 2'd3
	} cause_t;

	typedef enum logic [13:0] {
		PH_GVER   = 14'b00000000000001,
		PH_GNUM   = 14'b00000000000010,
		PH_GMETH  = 14'b00000000000100,
		PH_RVER   = 14'b00000000001000,
		PH_RCMD   = 14'b00000000010000,
		PH_RRSV   = 14'b00000000100000,
		PH_RATYP  = 14'b00000001000000,
		PH_DLEN   = 14'b00000010000000,
		PH_ADDR   = 14'b00000100000000,
		PH_PORTHI = 14'b00001000000000,
		PH_PORTLO = 14'b00010000000000,
		PH_WAIT   = 14'b00100000000000,
		PH_RELAY  = 14'b01000000000000,
		PH_CLOSED = 14'b10000000000000
	} phase_t;

	// One burst of results caused by one beat. count == 0: nothing to send.
	typedef struct packed {
		logic [3:0]  count;
		logic        is_seq;
		logic        close_tail;
		logic [7:0]  code;
		logic [1:0]  cause;
		logic [2:0]  kind;
		logic [7:0]  data;
		logic [1:0]  atyp;
		logic [15:0] port;
	} burst_t;

	typedef struct packed {
		logic       busy;
		logic [3:0] idx;
		logic [3:0] count;
	} emit_stat_t;

	function automatic logic [7:0] reply_code(input logic [1:0] oc);
		logic [7:0] r;
		unique case (oc)
			2'd0: r = 8'd0;
			2'd1: r = 8'd5;
			2'd2: r = 8'd3;
			default: r = 8'd4;
		endcase
		return r;
	endfunction

	function automatic burst_t mk_single(input kind_t k, input logic [7:0] d,
			input logic [1:0] at, input logic [15:0] p);
		burst_t b;
		b = '0;
		b.count = 4'd1;
		b.kind  = k;
		b.data  = d;
		b.atyp  = at;
		b.port  = p;
		return b;
	endfunction

	function automatic burst_t mk_close(input cause_t c);
		burst_t b;
		b = '0;
		b.count = 4'd1;
		b.kind  = KIND_CLOSE;
		b.cause = c;
		return b;
	endfunction

	function automatic burst_t mk_seq(input logic [7:0] code, input logic [3:0] n,
			input logic cl, input cause_t c);
		burst_t b;
		b = '0;
		b.count      = n;
		b.is_seq     = 1'b1;
		b.close_tail = cl;
		b.code       = code;
		b.cause      = c;
		return b;
	endfunction

endpackage

// ----- rtl/sh5_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh5_event_if / sh5_result_if
// Valid/ready channels for input events and result items.
// ----------------------------------------------------------------------------
interface sh5_event_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] data_byte;
	logic [1:0] outcome;

	modport source (output valid, func, data_byte, outcome, input ready);
	modport sink   (input valid, func, data_byte, outcome, output ready);
endinterface

interface sh5_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  out_kind;
	logic [7:0]  out_byte;
	logic [1:0]  dest_type;
	logic [15:0] dest_port;
	logic [1:0]  close_cause;
	logic        last;

	modport source (output valid, out_kind, out_byte, dest_type, dest_port,
		close_cause, last, input ready);
	modport sink   (input valid, out_kind, out_byte, dest_type, dest_port,
		close_cause, last, output ready);
endinterface

// ----- rtl/sh5_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh5_parser
// Handshake state and per-beat decode into a burst descriptor.
// ----------------------------------------------------------------------------
module sh5_parser
	import sh5_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [1:0] func,
	input  logic [7:0] data_byte,
	input  logic [1:0] outcome,
	output burst_t     burst
);

	phase_t     phase_q, phase_n;
	logic [7:0] cnt_q, cnt_n;
	logic [7:0] mcnt_q, mcnt_n;
	logic       noauth_q, noauth_n;
	logic       connect_q, connect_n;
	logic [1:0] dkind_q, dkind_n;
	logic [7:0] port_hi_q, port_hi_n;
	logic [7:0] nlen_q, nlen_n;

	logic [7:0] cnt_inc;
	logic [7:0] alen;
	logic       seen0;

	assign cnt_inc = cnt_q + 8'd1;
	assign seen0   = noauth_q | (data_byte == 8'd0);

	always_comb begin
		priority if (dkind_q == DK_IPV4) alen = LEN_IPV4;
		else if (dkind_q == DK_IPV6)     alen = LEN_IPV6;
		else                             alen = nlen_q;
	end

	always_comb begin
		phase_n   = phase_q;
		cnt_n     = cnt_q;
		mcnt_n    = mcnt_q;
		noauth_n  = noauth_q;
		connect_n = connect_q;
		dkind_n   = dkind_q;
		port_hi_n = port_hi_q;
		nlen_n    = nlen_q;
		burst     = '0;

		priority if (phase_q == PH_CLOSED) begin
		end else if (func == FUNC_HANGUP) begin
			burst   = mk_close(CAUSE_HANGUP);
			phase_n = PH_CLOSED;
		end else if (phase_q == PH_WAIT) begin
			if (func == FUNC_OUTCOME) begin
				if (outcome == 2'd0) begin
					burst   = mk_seq(reply_code(outcome), N_REPLY, 1'b0, CAUSE_PROTO);
					phase_n = PH_RELAY;
				end else begin
					burst   = mk_seq(reply_code(outcome), N_REPLY_CL, 1'b1, CAUSE_HANGUP);
					phase_n = PH_CLOSED;
				end
			end
		end else if (phase_q == PH_RELAY) begin
			if (func == FUNC_CLIENT)
				burst = mk_single(KIND_REMOTE, data_byte, 2'd0, 16'd0);
			else if (func == FUNC_REMOTE)
				burst = mk_single(KIND_CLIENT, data_byte, 2'd0, 16'd0);
		end else if (func == FUNC_CLIENT) begin
			unique case (phase_q)
				PH_GVER: begin
					if (data_byte != PROTO_VER) begin
						burst   = mk_close(CAUSE_PROTO);
						phase_n = PH_CLOSED;
					end else phase_n = PH_GNUM;
				end
				PH_GNUM: begin
					if (data_byte == 8'd0) begin
						burst   = mk_close(CAUSE_PROTO);
						phase_n = PH_CLOSED;
					end else begin
						mcnt_n   = data_byte;
						cnt_n    = 8'd0;
						noauth_n = 1'b0;
						phase_n  = PH_GMETH;
					end
				end
				PH_GMETH: begin
					noauth_n = seen0;
					cnt_n    = cnt_inc;
					if (cnt_inc >= mcnt_q) begin
						if (seen0) begin
							burst   = mk_seq(8'd0, N_GREET_OK, 1'b0, CAUSE_PROTO);
							phase_n = PH_RVER;
						end else begin
							burst   = mk_seq(NO_METHOD, N_GREET_NO, 1'b1, CAUSE_NOAUTH);
							phase_n = PH_CLOSED;
						end
					end
				end
				PH_RVER: begin
					if (data_byte != PROTO_VER) begin
						burst   = mk_close(CAUSE_PROTO);
						phase_n = PH_CLOSED;
					end else phase_n = PH_RCMD;
				end
				PH_RCMD: begin
					connect_n = (data_byte == REQ_CONNECT);
					phase_n   = PH_RRSV;
				end
				PH_RRSV: begin
					if (data_byte != 8'd0) begin
						burst   = mk_close(CAUSE_PROTO);
						phase_n = PH_CLOSED;
					end else phase_n = PH_RATYP;
				end
				PH_RATYP: begin
					cnt_n = 8'd0;
					priority if (data_byte == AT_CODE_V4) begin
						dkind_n = DK_IPV4;
						phase_n = PH_ADDR;
					end else if (data_byte == AT_CODE_V6) begin
						dkind_n = DK_IPV6;
						phase_n = PH_ADDR;
					end else if (data_byte == AT_CODE_NAME) begin
						dkind_n = DK_DOMAIN;
						phase_n = PH_DLEN;
					end else begin
						burst   = mk_close(CAUSE_PROTO);
						phase_n = PH_CLOSED;
					end
				end
				PH_DLEN: begin
					if (data_byte == 8'd0) begin
						burst   = mk_close(CAUSE_PROTO);
						phase_n = PH_CLOSED;
					end else begin
						nlen_n  = data_byte;
						cnt_n   = 8'd0;
						phase_n = PH_ADDR;
					end
				end
				PH_ADDR: begin
					if (connect_q)
						burst = mk_single(KIND_ADDR, data_byte, dkind_q, 16'd0);
					cnt_n = cnt_inc;
					if (cnt_inc >= alen) phase_n = PH_PORTHI;
				end
				PH_PORTHI: begin
					port_hi_n = data_byte;
					phase_n   = PH_PORTLO;
				end
				PH_PORTLO: begin
					if (connect_q) begin
						burst   = mk_single(KIND_CONNECT, 8'd0, dkind_q,
							{port_hi_q, data_byte});
						phase_n = PH_WAIT;
					end else begin
						burst   = mk_seq(REP_UNSUPPORTED, N_REPLY_CL, 1'b1, CAUSE_CMD);
						phase_n = PH_CLOSED;
					end
				end
				default: phase_n = PH_CLOSED;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_GVER;
			cnt_q     <= 8'd0;
			mcnt_q    <= 8'd0;
			noauth_q  <= 1'b0;
			connect_q <= 1'b0;
			dkind_q   <= DK_IPV4;
			port_hi_q <= 8'd0;
			nlen_q    <= 8'd0;
		end else if (fire) begin
			phase_q   <= phase_n;
			cnt_q     <= cnt_n;
			mcnt_q    <= mcnt_n;
			noauth_q  <= noauth_n;
			connect_q <= connect_n;
			dkind_q   <= dkind_n;
			port_hi_q <= port_hi_n;
			nlen_q    <= nlen_n;
		end
	end

endmodule

// ----- rtl/sh5_emitter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh5_emitter
// Result register: holds one burst and plays it out one item per beat.
// ----------------------------------------------------------------------------
module sh5_emitter
	import sh5_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  burst_t      burst,
	output logic        take_ok,
	output emit_stat_t  stat,
	sh5_result_if.source results
);

	burst_t     desc_q;
	logic       busy_q;
	logic [3:0] idx_q;
	logic       at_last;
	logic [7:0] seq_byte;

	assign at_last = (idx_q == desc_q.count - 4'd1);
	assign take_ok = !busy_q || (results.ready && at_last);

	assign stat.busy  = busy_q;
	assign stat.idx   = idx_q;
	assign stat.count = desc_q.count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 4'd0;
		end else if (take_ok) begin
			busy_q <= load;
			idx_q  <= 4'd0;
		end else if (results.ready) begin
			idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_ok && load) desc_q <= burst;
	end

	// reply layout: ver, code, rsv, atyp 1, then zero bind address and port
	always_comb begin
		priority if (idx_q == 4'd0)       seq_byte = PROTO_VER;
		else if (idx_q == 4'd1)           seq_byte = desc_q.code;
		else if (idx_q == REPLY_ATYP_IDX) seq_byte = AT_CODE_V4;
		else                              seq_byte = 8'd0;
	end

	always_comb begin
		results.valid       = busy_q;
		results.last        = at_last;
		results.out_kind    = desc_q.kind;
		results.out_byte    = desc_q.data;
		results.dest_type   = desc_q.atyp;
		results.dest_port   = desc_q.port;
		results.close_cause = (desc_q.kind == KIND_CLOSE) ? desc_q.cause : 2'd0;
		if (desc_q.is_seq) begin
			results.dest_type = 2'd0;
			results.dest_port = 16'd0;
			if (desc_q.close_tail && at_last) begin
				results.out_kind    = KIND_CLOSE;
				results.out_byte    = 8'd0;
				results.close_cause = desc_q.cause;
			end else begin
				results.out_kind    = KIND_CLIENT;
				results.out_byte    = seq_byte;
				results.close_cause = 2'd0;
			end
		end
	end

endmodule

// ----- rtl/socks5_handshake_parser_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// socks5_handshake_parser_top
// Server side of the SOCKS5 greeting/request exchange, one beat per event.
// ----------------------------------------------------------------------------
//  channel   dir   payload                                          handshake
//  events    in    func, data_byte, outcome                         valid/ready
//  results   out   out_kind, out_byte, dest_type, dest_port,        valid/ready
//                  close_cause, last
//
//  An event is decoded in the cycle it is taken; its results appear from the
//  next cycle, one per beat. Events causing zero or one result flow at one
//  per cycle while results are taken. A burst of n results (2 or 3 for
//  greeting replies, 10 or 11 for request replies) keeps events out while
//  the single result register plays out the burst; the next event goes with
//  the last item. arst_n clears the handshake state; the result register
//  then holds nothing. A stalled result holds events off while it waits.
// ----------------------------------------------------------------------------
module socks5_handshake_parser_top
	import sh5_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	sh5_event_if.sink     events,
	sh5_result_if.source  results
);

	burst_t     burst;
	emit_stat_t stat;
	logic       take_ok;
	logic       fire;

	assign events.ready = take_ok;
	assign fire         = events.valid && take_ok;

	sh5_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.func      (events.func),
		.data_byte (events.data_byte),
		.outcome   (events.outcome),
		.burst     (burst)
	);

	sh5_emitter u_emitter (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (fire && (burst.count != 4'd0)),
		.burst   (burst),
		.take_ok (take_ok),
		.stat    (stat),
		.results (results)
	);

	a_idx_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> (stat.idx < stat.count))
		else $error("item index past end of burst");

	a_idle_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!stat.busy |-> events.ready)
		else $error("idle block refuses an event");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.ready && results.last && !fire) |=> !results.valid)
		else $error("result after burst end without new event");

	a_close_last: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && (results.out_kind == KIND_CLOSE)) |-> results.last)
		else $error("close is not the final item");

endmodule
